// ===== rtl/sorted_record_table_with_stats_unit_macros.svh =====
// assertion macros for the sorted record table
`ifndef SORTED_RECORD_TABLE_WITH_STATS_UNIT_MACROS_SVH
`define SORTED_RECORD_TABLE_WITH_STATS_UNIT_MACROS_SVH

// implication checked on every clock edge outside reset
`define SRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define SRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srt_stats_pkg.sv =====
// shared types and constants for the sorted record table
package srt_stats_pkg;

    localparam int unsigned TableDepthDefault = 128;
    localparam int unsigned KeyWidth          = 16;
    localparam int unsigned ScoreWidth        = 14;
    localparam int unsigned CountWidth        = 8;

    // request codes
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_STATS  = 2'd2,
        REQ_NOP    = 2'd3
    } t_req;

    // status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

endpackage

// ===== rtl/srt_stats_if.sv =====
// valid/ready channel interfaces for requests and results
interface srt_stats_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             req_type;
    logic [srt_stats_pkg::KeyWidth-1:0]     record_key;
    logic [srt_stats_pkg::ScoreWidth-1:0]   score_in;

    modport source (output valid, req_type, record_key, score_in, input ready);
    modport sink   (input valid, req_type, record_key, score_in, output ready);
endinterface

interface srt_stats_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic [srt_stats_pkg::CountWidth-1:0]   entry_count;
    logic [srt_stats_pkg::ScoreWidth-1:0]   score_max;
    logic [srt_stats_pkg::ScoreWidth-1:0]   score_min;
    logic [srt_stats_pkg::ScoreWidth-1:0]   score_mean;
    logic [srt_stats_pkg::ScoreWidth-1:0]   score_deviation;

    modport source (output valid, status, entry_count, score_max, score_min,
                    score_mean, score_deviation, input ready);
    modport sink   (input valid, status, entry_count, score_max, score_min,
                    score_mean, score_deviation, output ready);
endinterface

// ===== rtl/srt_ram.sv =====
// generic single-port-write, one-read ram with registered read
module srt_ram #(
    parameter int unsigned Width = 16,
    parameter int unsigned Depth = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/sorted_record_table_with_stats_unit.sv =====
// Sorted record table with score statistics. Holds up to TABLE_DEPTH records
// (16-bit key, 14-bit score) in ascending key order in two single-port-write
// rams. One request is taken at a time; the request port stays low until its
// result has been taken. An insert walks from the end downward, reading each
// record and moving it up one place until the new record's slot is found. A
// delete scans the whole table, then moves the tail up one record at a time.
// Statistics scan the scores once with a 14x14 squaring multiplier and
// accumulators, then run one shared shift-subtract unit: one bit a cycle for
// the mean, a shift-add for the numerator, one bit a cycle for the variance
// division and two bits a cycle for the square root. No clearing pass after
// reset.
module sorted_record_table_with_stats_unit #(
    parameter int unsigned TABLE_DEPTH = srt_stats_pkg::TableDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    srt_stats_req_if.sink   i_req,
    srt_stats_rsp_if.source o_rsp
);
    `include "sorted_record_table_with_stats_unit_macros.svh"

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned KW = srt_stats_pkg::KeyWidth;
    localparam int unsigned SW = srt_stats_pkg::ScoreWidth;
    localparam int unsigned OW = srt_stats_pkg::CountWidth;
    // sum of scores, sum of squares, widest quotient terms
    localparam int unsigned SUMW = SW + CW;
    localparam int unsigned SQW  = 2 * SW + CW;
    localparam int unsigned NUMW = SQW + CW;
    localparam int unsigned DW   = (NUMW > SUMW) ? NUMW : SUMW;
    localparam int unsigned RW   = (NUMW + 1) / 2;

    typedef enum logic [3:0] {
        S_IDLE, S_INS_RD, S_INS_CMP, S_DEL_SCAN, S_DEL_RD, S_DEL_WR,
        S_ST_SCAN, S_ST_MEAN, S_ST_NUM, S_ST_VAR, S_ST_SQRT, S_RESP
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_pos;      // walking index
    logic [CW-1:0] r_idx;      // last matching index for delete
    logic          r_found;
    logic          r_rvalid;   // read issued last cycle
    logic [CW-1:0] r_rpos;     // address of data arriving
    logic [1:0]    r_req;
    logic [KW-1:0] r_key;
    logic [SW-1:0] r_score;
    logic [SUMW-1:0] r_sum;
    logic [SQW-1:0]  r_sumsq;
    logic [SW-1:0]   r_max, r_min;
    logic [DW-1:0]   r_rem;     // shared divider / root remainder
    logic [DW-1:0]   r_quo;     // shared quotient / dividend shift
    logic [DW-1:0]   r_den;
    logic [RW-1:0]   r_root;
    logic [6:0]      r_step;
    logic [SW-1:0]   r_mean;
    logic [1:0]      r_status;
    logic            r_ovalid;
    logic [SW-1:0]   r_dev;

    logic [KW-1:0] w_key_rd;
    logic [SW-1:0] w_sc_rd;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [KW-1:0] w_kwr;
    logic [SW-1:0] w_swr;
    logic [2*SW-1:0] w_sq;

    srt_ram #(.Width(KW), .Depth(TABLE_DEPTH)) u_keys (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_kwr),
        .i_raddr(w_raddr), .o_rdata(w_key_rd));
    srt_ram #(.Width(SW), .Depth(TABLE_DEPTH)) u_scores (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_swr),
        .i_raddr(w_raddr), .o_rdata(w_sc_rd));

    assign w_sq = w_sc_rd * w_sc_rd;

    // ram address and write control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos[AW-1:0];
        w_raddr = r_pos[AW-1:0];
        w_kwr   = w_key_rd;
        w_swr   = w_sc_rd;
        case (r_state)
            S_INS_RD: begin
                w_raddr = AW'(r_pos - CW'(1));
            end
            S_INS_CMP: begin
                w_we = 1'b1;
                if (r_pos != '0 && w_key_rd > r_key) begin
                    w_kwr = w_key_rd;
                    w_swr = w_sc_rd;
                end else begin
                    w_kwr = r_key;
                    w_swr = r_score;
                end
            end
            S_DEL_RD: begin
                w_raddr = AW'(r_pos + CW'(1));
            end
            S_DEL_WR: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // remainder trial for the shared shift-subtract unit
    logic [DW:0]   w_trial;
    logic [DW-1:0] w_rsh;
    logic [RW+1:0] w_rt;
    logic [DW:0]   w_rtrial;
    always_comb begin
        w_rsh    = {r_rem[DW-2:0], r_quo[DW-1]};
        w_trial  = {1'b0, w_rsh} - {1'b0, r_den};
        w_rt     = {r_root, 2'b01};
        w_rtrial = {1'b0, r_rem[DW-3:0], r_quo[DW-1:DW-2]} - (DW+1)'(w_rt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req   <= i_req.req_type;
                        r_key   <= i_req.record_key;
                        r_score <= i_req.score_in;
                        r_max <= '0; r_mean <= '0; r_dev <= '0;
                        r_found <= 1'b0; r_rvalid <= 1'b0;
                        r_sum <= '0; r_sumsq <= '0;
                        case (i_req.req_type)
                            srt_stats_pkg::REQ_INSERT: begin
                                r_min <= '0;
                                if (r_fill >= CW'(TABLE_DEPTH)) begin
                                    r_pos    <= '0;
                                    r_status <= srt_stats_pkg::ST_FULL;
                                    r_state  <= S_RESP;
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_pos    <= r_fill;
                                    r_status <= srt_stats_pkg::ST_OK;
                                    r_state  <= S_INS_RD;
                                end
                            end
                            srt_stats_pkg::REQ_DELETE: begin
                                r_min    <= '0;
                                r_pos    <= '0;
                                r_status <= srt_stats_pkg::ST_OK;
                                r_state  <= S_DEL_SCAN;
                            end
                            srt_stats_pkg::REQ_STATS: begin
                                r_pos <= '0;
                                if (r_fill == '0) begin
                                    r_min    <= '0;
                                    r_status <= srt_stats_pkg::ST_EMPTY;
                                    r_state  <= S_RESP;
                                    r_ovalid <= 1'b1;
                                end else begin
                                    r_min    <= '1;
                                    r_status <= srt_stats_pkg::ST_OK;
                                    r_state  <= S_ST_SCAN;
                                end
                            end
                            default: begin
                                r_min    <= '0;
                                r_pos    <= '0;
                                r_status <= srt_stats_pkg::ST_OK;
                                r_state  <= S_RESP;
                                r_ovalid <= 1'b1;
                            end
                        endcase
                    end
                end
                // insert: read pos-1, then shift it up or place the record
                S_INS_RD: begin
                    r_state <= S_INS_CMP;
                end
                S_INS_CMP: begin
                    if (r_pos != '0 && w_key_rd > r_key) begin
                        r_pos   <= r_pos - CW'(1);
                        r_state <= S_INS_RD;
                    end else begin
                        r_fill   <= r_fill + CW'(1);
                        r_state  <= S_RESP;
                        r_ovalid <= 1'b1;
                    end
                end
                // delete: scan all keys with one read in flight
                S_DEL_SCAN: begin
                    r_rvalid <= (r_pos < r_fill);
                    r_rpos   <= r_pos;
                    if (r_pos < r_fill) begin
                        r_pos <= r_pos + CW'(1);
                    end
                    if (r_rvalid && w_key_rd == r_key) begin
                        r_found <= 1'b1;
                        r_idx   <= r_rpos;
                    end
                    if (!r_rvalid && r_pos >= r_fill) begin
                        if (r_found) begin
                            r_pos   <= r_idx;
                            r_state <= S_DEL_RD;
                        end else begin
                            r_status <= srt_stats_pkg::ST_NOTFOUND;
                            r_state  <= S_RESP;
                            r_ovalid <= 1'b1;
                        end
                    end
                end
                S_DEL_RD: begin
                    if (r_pos + CW'(1) >= r_fill) begin
                        r_fill   <= r_fill - CW'(1);
                        r_state  <= S_RESP;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_state <= S_DEL_WR;
                    end
                end
                S_DEL_WR: begin
                    r_pos   <= r_pos + CW'(1);
                    r_state <= S_DEL_RD;
                end
                // statistics: accumulate sum, squares, max and min
                S_ST_SCAN: begin
                    r_rvalid <= (r_pos < r_fill);
                    if (r_pos < r_fill) begin
                        r_pos <= r_pos + CW'(1);
                    end
                    if (r_rvalid) begin
                        r_sum   <= r_sum + SUMW'(w_sc_rd);
                        r_sumsq <= r_sumsq + SQW'(w_sq);
                        if (w_sc_rd > r_max) r_max <= w_sc_rd;
                        if (w_sc_rd < r_min) r_min <= w_sc_rd;
                    end
                    if (!r_rvalid && r_pos >= r_fill) begin
                        r_rem   <= '0;
                        r_quo   <= DW'(r_sum);
                        r_den   <= DW'(r_fill);
                        r_step  <= 7'(DW);
                        r_state <= S_ST_MEAN;
                    end
                end
                // shared divider: sum / n
                S_ST_MEAN: begin
                    if (r_step == '0) begin
                        r_mean  <= SW'(r_quo);
                        // numerator built one term per cycle next
                        r_rem   <= DW'(r_sumsq);
                        r_state <= S_ST_NUM;
                        r_step  <= 7'(CW);
                        r_quo   <= '0;
                        r_den   <= DW'(r_fill);
                    end else begin
                        r_step <= r_step - 7'd1;
                        if (!w_trial[DW]) begin
                            r_rem <= w_trial[DW-1:0];
                            r_quo <= {r_quo[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[DW-2:0], 1'b0};
                        end
                    end
                end
                // shift-add n * sumsq, then subtract sum squared
                S_ST_NUM: begin
                    if (r_step == '0) begin
                        r_rem  <= '0;
                        r_quo  <= r_quo - DW'(r_sum * r_sum);
                        r_den  <= DW'(r_fill * r_fill);
                        r_step <= 7'(DW);
                        r_state <= S_ST_VAR;
                    end else begin
                        r_step <= r_step - 7'd1;
                        if (r_den[0]) r_quo <= r_quo + r_rem;
                        r_rem <= {r_rem[DW-2:0], 1'b0};
                        r_den <= {1'b0, r_den[DW-1:1]};
                    end
                end
                // shared divider: numerator / n^2
                S_ST_VAR: begin
                    if (r_step == '0) begin
                        r_rem  <= '0;
                        r_root <= '0;
                        r_step <= 7'(DW / 2);
                        r_state <= S_ST_SQRT;
                    end else begin
                        r_step <= r_step - 7'd1;
                        if (!w_trial[DW]) begin
                            r_rem <= w_trial[DW-1:0];
                            r_quo <= {r_quo[DW-2:0], 1'b1};
                        end else begin
                            r_rem <= w_rsh;
                            r_quo <= {r_quo[DW-2:0], 1'b0};
                        end
                    end
                end
                // restoring square root, two bits a cycle
                S_ST_SQRT: begin
                    if (r_step == '0) begin
                        r_dev    <= SW'(r_root);
                        r_state  <= S_RESP;
                        r_ovalid <= 1'b1;
                    end else begin
                        r_step <= r_step - 7'd1;
                        r_quo  <= {r_quo[DW-3:0], 2'b00};
                        if (!w_rtrial[DW]) begin
                            r_rem  <= w_rtrial[DW-1:0];
                            r_root <= {r_root[RW-2:0], 1'b1};
                        end else begin
                            r_rem  <= {r_rem[DW-3:0], r_quo[DW-1:DW-2]};
                            r_root <= {r_root[RW-2:0], 1'b0};
                        end
                    end
                end
                S_RESP: begin
                    if (o_rsp.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_ovalid;
    assign o_rsp.status          = r_status;
    assign o_rsp.entry_count     = OW'(r_fill);
    assign o_rsp.score_max       = (r_req == srt_stats_pkg::REQ_STATS) ? r_max : '0;
    assign o_rsp.score_min       = (r_req == srt_stats_pkg::REQ_STATS) ? r_min : '0;
    assign o_rsp.score_mean      = r_mean;
    assign o_rsp.score_deviation = r_dev;

    `SRT_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(TABLE_DEPTH),
        "fill count above table depth")
    `SRT_ASSERT_IMP(a_valid_resp, i_clk, i_rst_n, r_ovalid, r_state == S_RESP,
        "result shown outside response state")
    `SRT_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n,
        i_req.valid && i_req.ready && r_fill == CW'(TABLE_DEPTH)
        && i_req.req_type == srt_stats_pkg::REQ_INSERT,
        r_status == srt_stats_pkg::ST_FULL && r_fill == CW'(TABLE_DEPTH),
        "insert at capacity changed table")
endmodule
